>>> design/ps2_mouse_packet_tracker_top_defines.svh
// assertion macros for the ps2 mouse packet tracker
// expects clk and rst_n in the scope where a macro is used
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define PS2MT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PS2MT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ps2mt_pkg.sv
// shared types and constants for the ps2 mouse packet tracker
// no dependencies
`timescale 1ns / 1ps

package ps2mt_pkg;

  // byte position inside a three-byte packet
  typedef enum logic [1:0] {
    BI_FLAGS = 2'd0,
    BI_DX    = 2'd1,
    BI_DY    = 2'd2
  } byte_idx_t;

  // one assembled packet
  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  // flags byte bit positions
  localparam int unsigned FLG_ALWAYS1 = 3;
  localparam int unsigned FLG_XSIGN   = 4;
  localparam int unsigned FLG_YSIGN   = 5;
  localparam int unsigned FLG_XOVF    = 6;
  localparam int unsigned FLG_YOVF    = 7;

  localparam int unsigned BTN_W   = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 1'b1;

  // magnitude of a negative 9-bit delta is span minus its low byte
  localparam logic [8:0] DELTA_SPAN = 9'd256;

endpackage

>>> design/ps2mt_framer.sv
// groups incoming bytes into packets and holds the packet register
// depends on ps2mt_pkg
`timescale 1ns / 1ps

module ps2mt_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              pkt_valid,
  output ps2mt_pkg::pkt_t   pkt,
  input  logic              pkt_take
);

  ps2mt_pkg::byte_idx_t idx_r, idx_nxt;
  logic [7:0]           flags_r, flags_nxt;
  logic [7:0]           dx_r, dx_nxt;
  logic                 pkt_v_r, pkt_v_nxt;
  ps2mt_pkg::pkt_t      pkt_r, pkt_nxt;
  logic                 acc;

  // packet register frees up when taken
  assign in_ready  = !pkt_v_r || pkt_take;
  assign acc       = in_valid && in_ready;
  assign pkt_valid = pkt_v_r;
  assign pkt       = pkt_r;

  // byte position sequencing
  always_comb begin
    idx_nxt   = idx_r;
    flags_nxt = flags_r;
    dx_nxt    = dx_r;
    pkt_nxt   = pkt_r;
    pkt_v_nxt = pkt_v_r && !pkt_take;
    if (acc) begin
      case (idx_r)
        ps2mt_pkg::BI_DX: begin
          dx_nxt  = in_rx_byte;
          idx_nxt = ps2mt_pkg::BI_DY;
        end
        ps2mt_pkg::BI_DY: begin
          pkt_nxt.flags = flags_r;
          pkt_nxt.dx    = dx_r;
          pkt_nxt.dy    = in_rx_byte;
          pkt_v_nxt     = 1'b1;
          idx_nxt       = ps2mt_pkg::BI_FLAGS;
        end
        default: begin
          flags_nxt = in_rx_byte;
          idx_nxt   = ps2mt_pkg::BI_DX;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= ps2mt_pkg::BI_FLAGS;
      pkt_v_r <= 1'b0;
      flags_r <= 8'd0;
      dx_r    <= 8'd0;
    end else begin
      idx_r   <= idx_nxt;
      pkt_v_r <= pkt_v_nxt;
      flags_r <= flags_nxt;
      dx_r    <= dx_nxt;
    end
  end

  // packet payload
  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

endmodule

>>> design/ps2mt_axis.sv
// one axis: move by a 9-bit magnitude without going below zero, then clamp
// depends on nothing; parameterized by position width
`timescale 1ns / 1ps

module ps2mt_axis #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic [POS_BITS-1:0] pos,
  input  logic [8:0]          mag,
  input  logic                sub,
  input  logic                apply,
  input  logic [POS_BITS-1:0] lim,
  output logic [POS_BITS-1:0] pos_new
);

  localparam int unsigned SW = ((POS_BITS > 9) ? POS_BITS : 9) + 1;

  logic [SW-1:0] pos_w;
  logic [SW-1:0] mag_w;
  logic [SW-1:0] lim_w;
  logic [SW-1:0] moved;

  assign pos_w = SW'(pos);
  assign mag_w = SW'(mag);
  assign lim_w = SW'(lim);

  // move, holding the axis where it would go negative
  always_comb begin
    if (!apply) begin
      moved = pos_w;
    end else if (!sub) begin
      moved = pos_w + mag_w;
    end else if (pos_w >= mag_w) begin
      moved = pos_w - mag_w;
    end else begin
      moved = pos_w;
    end
  end

  // clamp to the limit
  assign pos_new = (moved > lim_w) ? lim : POS_BITS'(moved);

endmodule

>>> design/ps2_mouse_packet_tracker_top.sv
// top level of the ps2 mouse packet tracker: config, cursor state, result register
// depends on ps2mt_pkg, ps2mt_framer, ps2mt_axis and the defines header
//
//   channel | signals                                            | dir
//   in      | in_valid, in_ready, in_rx_byte                     | in
//   out     | out_valid, out_ready, out_pos_x, out_pos_y,        | out
//           | out_button_bits, out_packet_ok                     |
//   cfg     | cfg_we, cfg_index, cfg_wdata                       | in
//
// one byte is taken per cycle unless input is stalled; every third byte lands
// in the packet register and moves to the output register once that is free
// the cursor update is one add or subtract plus two compares per axis
// synchronous active-low reset clears position, buttons, limits and framing
// a stalled output holds the packet register, which then stalls input
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_top_defines.svh"

module ps2_mouse_packet_tracker_top #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [2:0]  out_button_bits,
  output logic        out_packet_ok,
  input  logic        cfg_we,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mt_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [ps2mt_pkg::CFG_W-1:0] max_x_r, max_y_r;
  logic [POS_BITS-1:0]         cursor_x_r, cursor_y_r;
  logic [POS_BITS-1:0]         cursor_x_nxt, cursor_y_nxt;
  logic [POS_BITS-1:0]         lim_x, lim_y;
  logic [ps2mt_pkg::BTN_W-1:0] buttons_r, buttons_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [15:0]                 pos_x_r, pos_y_r;
  logic [ps2mt_pkg::BTN_W-1:0] btn_out_r;
  logic                        ok_out_r;

  logic                        pkt_valid;
  ps2mt_pkg::pkt_t             pkt;
  logic                        pkt_take;
  logic                        ok;
  logic [8:0]                  mag_x, mag_y;
  logic                        sub_x, sub_y;

  // byte framing and packet register
  ps2mt_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .pkt_valid  (pkt_valid),
    .pkt        (pkt),
    .pkt_take   (pkt_take)
  );

  assign pkt_take = pkt_valid && (!out_valid_r || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= '0;
      max_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mt_pkg::CFG_MAX_X: max_x_r <= cfg_wdata;
        ps2mt_pkg::CFG_MAX_Y: max_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lim_x = POS_BITS'(max_x_r);
  assign lim_y = POS_BITS'(max_y_r);

  // packet checks and delta decode
  assign ok = !pkt.flags[ps2mt_pkg::FLG_XOVF] && !pkt.flags[ps2mt_pkg::FLG_YOVF]
              && pkt.flags[ps2mt_pkg::FLG_ALWAYS1];

  // x adds the delta, y subtracts it
  assign sub_x = pkt.flags[ps2mt_pkg::FLG_XSIGN];
  assign mag_x = sub_x ? (ps2mt_pkg::DELTA_SPAN - {1'b0, pkt.dx}) : {1'b0, pkt.dx};
  assign sub_y = !pkt.flags[ps2mt_pkg::FLG_YSIGN];
  assign mag_y = sub_y ? {1'b0, pkt.dy} : (ps2mt_pkg::DELTA_SPAN - {1'b0, pkt.dy});

  ps2mt_axis #(.POS_BITS(POS_BITS)) u_axis_x (
    .pos     (cursor_x_r),
    .mag     (mag_x),
    .sub     (sub_x),
    .apply   (ok),
    .lim     (lim_x),
    .pos_new (cursor_x_nxt)
  );

  ps2mt_axis #(.POS_BITS(POS_BITS)) u_axis_y (
    .pos     (cursor_y_r),
    .mag     (mag_y),
    .sub     (sub_y),
    .apply   (ok),
    .lim     (lim_y),
    .pos_new (cursor_y_nxt)
  );

  assign buttons_nxt = ok ? pkt.flags[ps2mt_pkg::BTN_W-1:0] : buttons_r;

  // output valid tracking
  always_comb begin
    if (pkt_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // cursor state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      buttons_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pkt_take) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        buttons_r  <= buttons_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pkt_take) begin
      pos_x_r   <= 16'(cursor_x_nxt);
      pos_y_r   <= 16'(cursor_y_nxt);
      btn_out_r <= buttons_nxt;
      ok_out_r  <= ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_button_bits = btn_out_r;
  assign out_packet_ok   = ok_out_r;

  // a result only appears after a packet transaction
  `PS2MT_ASSERT_NEXT(a_res_needs_pkt, !pkt_take && !out_valid_r, !out_valid_r, "result without packet")

  // cursor stays within limits after every packet
  `PS2MT_ASSERT_NEXT(a_cursor_in_lim, pkt_take, (cursor_x_r <= lim_x) && (cursor_y_r <= lim_y), "cursor past limit")

  // a dropped packet leaves the buttons alone
  `PS2MT_ASSERT_NEXT(a_drop_keeps_btn, pkt_take && !ok, $stable(buttons_r), "buttons changed on drop")

  // input is held off while the packet register is stuck behind a full output
  `PS2MT_ASSERT_NOW(a_stall_backs_up, pkt_valid && out_valid_r && !out_ready, !in_ready, "input taken while stalled")

endmodule

>>> tb/ps2mt_tb_pkg.sv
// cursor scoreboard for the ps2 mouse packet tracker testbench: predicts reports from bytes
// depends on ps2mt_pkg for byte slots, flag bit positions and register indexes
`timescale 1ns / 1ps

package ps2mt_tb_pkg;
  import ps2mt_pkg::*;

  // one report as seen on the output channel
  typedef struct packed {
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
    logic [BTN_W-1:0] buttons;
    logic             ok;
  } cursor_report_t;

  class cursor_scoreboard;
    logic [CFG_W-1:0] limit_x;
    logic [CFG_W-1:0] limit_y;
    logic [15:0]      cur_x;
    logic [15:0]      cur_y;
    logic [BTN_W-1:0] held_buttons;
    byte_idx_t        next_slot;
    logic [7:0]       flags_seen;
    logic [7:0]       dx_seen;
    cursor_report_t   expected_reports[$];
    int               errors;

    function new();
      limit_x = '0;
      limit_y = '0;
      cur_x = '0;
      cur_y = '0;
      held_buttons = '0;
      next_slot = BI_FLAGS;
      flags_seen = '0;
      dx_seen = '0;
      errors = 0;
    endfunction

    function void set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      if (idx == CFG_MAX_X) begin
        limit_x = val;
      end else if (idx == CFG_MAX_Y) begin
        limit_y = val;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // accepted byte transaction: frame it, and on the third byte move the cursor
    function void note_byte(input logic [7:0] b);
      int             off_x;
      int             off_y;
      int             nx;
      int             ny;
      logic           ok;
      cursor_report_t rpt;
      case (next_slot)
        BI_DX: begin
          dx_seen = b;
          next_slot = BI_DY;
        end
        BI_DY: begin
          next_slot = BI_FLAGS;
          ok = !flags_seen[FLG_XOVF] && !flags_seen[FLG_YOVF] && flags_seen[FLG_ALWAYS1];
          nx = cur_x;
          ny = cur_y;
          if (ok) begin
            // 9-bit deltas; y moves opposite to its delta
            off_x = int'(dx_seen) - (flags_seen[FLG_XSIGN] ? int'(DELTA_SPAN) : 0);
            off_y = (flags_seen[FLG_YSIGN] ? int'(DELTA_SPAN) : 0) - int'(b);
            if (nx + off_x >= 0) nx = nx + off_x;
            if (ny + off_y >= 0) ny = ny + off_y;
            held_buttons = flags_seen[BTN_W-1:0];
          end
          // clamp applies to dropped packets as well
          if (nx > int'(limit_x)) nx = int'(limit_x);
          if (ny > int'(limit_y)) ny = int'(limit_y);
          cur_x = nx[15:0];
          cur_y = ny[15:0];
          rpt.pos_x = cur_x;
          rpt.pos_y = cur_y;
          rpt.buttons = held_buttons;
          rpt.ok = ok;
          expected_reports.push_back(rpt);
        end
        default: begin
          flags_seen = b;
          next_slot = BI_DX;
        end
      endcase
    endfunction

    // accepted report transaction: compare with the oldest prediction
    function void check_report(input logic [15:0] x, input logic [15:0] y,
                               input logic [BTN_W-1:0] btn, input logic ok);
      cursor_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report x=%0d y=%0d buttons=%0d ok=%0d",
                 $time, x, y, btn, ok);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (x !== want.pos_x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, x);
        errors++;
      end
      if (y !== want.pos_y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, y);
        errors++;
      end
      if (btn !== want.buttons) begin
        $display("%0t: button_bits expected %0d actual %0d", $time, want.buttons, btn);
        errors++;
      end
      if (ok !== want.ok) begin
        $display("%0t: packet_ok expected %0d actual %0d", $time, want.ok, ok);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb.sv
// top of the ps2 mouse packet tracker testbench: clock, reset, byte driver, report monitor
// depends on ps2mt_pkg, ps2mt_tb_pkg and ps2_mouse_packet_tracker_top
`timescale 1ns / 1ps

module tb;
  import ps2mt_pkg::*;
  import ps2mt_tb_pkg::*;

  typedef enum int {
    PACE_SEND_LIGHT,
    PACE_RECV_LIGHT,
    PACE_FULL
  } pace_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          out_pos_x;
  logic [15:0]          out_pos_y;
  logic [2:0]           out_button_bits;
  logic                 out_packet_ok;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  cursor_scoreboard cursor_sb;
  int               send_idle_pct = 25;
  int               recv_idle_pct = 56;
  bit               hold_off_req = 1'b0;

  ps2_mouse_packet_tracker_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_button_bits (out_button_bits),
    .out_packet_ok   (out_packet_ok),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  // run limit
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // report monitor: values are stable at the falling edge, accepted at the next rise
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      cursor_sb.check_report(out_pos_x, out_pos_y, out_button_bits, out_packet_ok);
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_SEND_LIGHT: begin
        send_idle_pct = 25;
        recv_idle_pct = 56;
      end
      PACE_RECV_LIGHT: begin
        send_idle_pct = 56;
        recv_idle_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // both limits written back to back, only while the block is idle
  task automatic set_limits(input logic [CFG_W-1:0] lim_x, input logic [CFG_W-1:0] lim_y);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_X;
    cfg_wdata <= lim_x;
    @(posedge clk);
    cursor_sb.set_limit(CFG_MAX_X, lim_x);
    cfg_index <= CFG_MAX_Y;
    cfg_wdata <= lim_y;
    @(posedge clk);
    cursor_sb.set_limit(CFG_MAX_Y, lim_y);
    cfg_we <= 1'b0;
  endtask

  // one byte transaction, with random idle cycles in front
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    cursor_sb.note_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] f, input logic [7:0] dx, input logic [7:0] dy);
    send_byte(f);
    send_byte(dx);
    send_byte(dy);
  endtask

  // stop offering, wait for every report, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (cursor_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed packets with random content, the rest raw noise
  task automatic send_random_packet();
    logic [7:0] f;
    f = 8'($urandom);
    if ($urandom_range(0, 99) < 80) begin
      f[FLG_XOVF] = 1'b0;
      f[FLG_YOVF] = 1'b0;
      f[FLG_ALWAYS1] = 1'b1;
    end
    if ($urandom_range(0, 3) == 0) begin
      send_packet(f, 8'($urandom_range(0, 3)), 8'($urandom_range(252, 255)));
    end else begin
      send_packet(f, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int         i;
    int         k;
    int         waited;
    logic [7:0] f;
    cursor_sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_pace(PACE_SEND_LIGHT);

    // zero limits: everything clamps to the origin
    set_limits(16'd0, 16'd0);
    send_packet(8'h0f, 8'h7f, 8'h80);
    send_packet(8'hff, 8'hff, 8'hff);
    settle();

    // widest limits: directed moves, drops and special cases
    set_limits(16'hffff, 16'hffff);
    send_packet(8'h08, 8'hff, 8'h00);  // x +255, zero y delta
    send_packet(8'h29, 8'h00, 8'h00);  // y up by 256, left button
    send_packet(8'h1a, 8'h00, 8'hff);  // x would go negative, y down
    send_packet(8'h4c, 8'h10, 8'h10);  // x overflow dropped
    send_packet(8'h8c, 8'h10, 8'h10);  // y overflow dropped
    send_packet(8'h07, 8'h01, 8'h01);  // always-one bit clear dropped
    send_packet(8'h3f, 8'h80, 8'h01);  // both signs, all buttons
    send_packet(8'h0e, 8'h00, 8'h00);  // zero deltas
    settle();

    // long run of large rightward and upward moves under changing pace
    for (i = 0; i < 90; i++) begin
      if (i % 30 == 0) set_pace(pace_t'((i / 30) % 3));
      if (i == 45) hold_off_req = 1'b1;
      f = 8'($urandom_range(0, 7));
      f[FLG_ALWAYS1] = 1'b1;
      f[FLG_YSIGN] = 1'b1;
      if ($urandom_range(0, 15) == 0) begin
        send_random_packet();
      end else begin
        send_packet(f, 8'($urandom_range(240, 255)), 8'($urandom_range(0, 24)));
      end
    end
    settle();

    // several limit settings with random traffic
    for (k = 0; k < 5; k++) begin
      case (k)
        0: set_limits(16'd0, 16'hffff);
        1: set_limits(16'd300, 16'd20);
        2: set_limits(16'hffff, 16'd0);
        3: set_limits(16'($urandom), 16'($urandom));
        default: set_limits(16'd1, 16'd1);
      endcase
      set_pace(pace_t'(k % 3));
      for (i = 0; i < 16; i++) begin
        send_random_packet();
      end
      settle();
    end

    // final drain with a bound
    waited = 0;
    while (cursor_sb.pending() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (cursor_sb.pending() != 0) begin
      $display("%0t: %0d reports never arrived", $time, cursor_sb.pending());
      cursor_sb.errors++;
    end
    if (cursor_sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ps2mt_pkg.sv
design/ps2mt_framer.sv
design/ps2mt_axis.sv
design/ps2_mouse_packet_tracker_top.sv
tb/ps2mt_tb_pkg.sv
tb/tb.sv
